### hw/rtl/mhxy_pkg.sv
// Shared types, constants and the arctangent table for the magnetic heading pipeline.
// No dependencies; every other file imports this package.
package mhxy_pkg;

   localparam int CORDIC_ITERATIONS   = 16;
   localparam int ANGLE_FRACTION_BITS = 6;
   localparam int ARC_TABLE_SIZE      = 24;
   localparam int CORDIC_STAGES       = (CORDIC_ITERATIONS < ARC_TABLE_SIZE) ?
                                        CORDIC_ITERATIONS : ARC_TABLE_SIZE;

   localparam int FIELD_WIDTH   = 16;
   localparam int INPUT_SHIFT   = 30;
   localparam int XY_WIDTH      = 48;
   localparam int Z_WIDTH       = 34;
   localparam int TURN_WIDTH    = 33;
   localparam int TURN_BITS     = 32;
   localparam int HEADING_WIDTH = 15;

   localparam longint HEADING_SCALE = 64'd360 << ANGLE_FRACTION_BITS;
   localparam int SCALE_WIDTH = $clog2(HEADING_SCALE + 1);
   localparam int PROD_WIDTH  = TURN_WIDTH + SCALE_WIDTH;
   localparam int ROUND_WIDTH = PROD_WIDTH + 1;

   // prerotate, CORDIC stages, clamp, multiply, round
   localparam int LATENCY = CORDIC_STAGES + 4;

   localparam logic signed [Z_WIDTH-1:0] HALF_TURN    = Z_WIDTH'(64'sd2147483648);
   localparam logic signed [Z_WIDTH-1:0] QUARTER_TURN = Z_WIDTH'(64'sd1073741824);

   localparam logic [HEADING_WIDTH-1:0] HEADING_AT_ZERO =
      HEADING_WIDTH'((HEADING_SCALE / 2) & ((64'd1 << HEADING_WIDTH) - 1));

   typedef struct packed {
      logic                       valid;
      logic                       bypass;
      logic signed [XY_WIDTH-1:0] x;
      logic signed [XY_WIDTH-1:0] y;
      logic signed [Z_WIDTH-1:0]  z;
   } cordic_item_type;

   // atan(2^-i) as a binary angle, full turn = 2^32
   function automatic logic signed [Z_WIDTH-1:0] arc_angle(input int idx);
      logic signed [Z_WIDTH-1:0] a;
      case (idx)
         0:       a = Z_WIDTH'(64'sd536870912);
         1:       a = Z_WIDTH'(64'sd316933406);
         2:       a = Z_WIDTH'(64'sd167458907);
         3:       a = Z_WIDTH'(64'sd85004756);
         4:       a = Z_WIDTH'(64'sd42667331);
         5:       a = Z_WIDTH'(64'sd21354465);
         6:       a = Z_WIDTH'(64'sd10679838);
         7:       a = Z_WIDTH'(64'sd5340245);
         8:       a = Z_WIDTH'(64'sd2670163);
         9:       a = Z_WIDTH'(64'sd1335087);
         10:      a = Z_WIDTH'(64'sd667544);
         11:      a = Z_WIDTH'(64'sd333772);
         12:      a = Z_WIDTH'(64'sd166886);
         13:      a = Z_WIDTH'(64'sd83443);
         14:      a = Z_WIDTH'(64'sd41722);
         15:      a = Z_WIDTH'(64'sd20861);
         16:      a = Z_WIDTH'(64'sd10430);
         17:      a = Z_WIDTH'(64'sd5215);
         18:      a = Z_WIDTH'(64'sd2608);
         19:      a = Z_WIDTH'(64'sd1304);
         20:      a = Z_WIDTH'(64'sd652);
         21:      a = Z_WIDTH'(64'sd326);
         22:      a = Z_WIDTH'(64'sd163);
         23:      a = Z_WIDTH'(64'sd81);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### hw/rtl/magnetic_heading_from_xy_top.sv
// Top level of the magnetic heading pipeline: X/Y sample in, compass heading out.
// Depends on mhxy_pkg, mhxy_prerot, mhxy_cordic and mhxy_scale.
//
//   channel   ports                               direction  marker
//   request   start, busy, req_field_x/y          in/out     start & !busy
//   response  rsp_strobe, rsp_heading             out        rsp_strobe
//
// One sample enters per cycle while busy is low; its heading leaves after the prerotate
// register, the unrolled CORDIC stages and the clamp, multiply and round registers.
// Synchronous reset empties the pipeline; busy is a registered copy of reset, so it is
// high in the cycle after each reset cycle and low otherwise. The receiver cannot stall, so
// nothing ever holds back the pipeline.
module magnetic_heading_from_xy_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [mhxy_pkg::FIELD_WIDTH-1:0]  req_field_x,
   input  logic signed [mhxy_pkg::FIELD_WIDTH-1:0]  req_field_y,
   output logic                                     rsp_strobe,
   output logic [mhxy_pkg::HEADING_WIDTH-1:0]       rsp_heading
);
   import mhxy_pkg::*;

   logic busy_ff;
   logic accept;
   cordic_item_type pre_item, cordic_item;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   mhxy_prerot u_prerot (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .field_x  (req_field_x),
      .field_y  (req_field_y),
      .item_out (pre_item)
   );

   mhxy_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .item_in  (pre_item),
      .item_out (cordic_item)
   );

   mhxy_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .item_in   (cordic_item),
      .out_valid (rsp_strobe),
      .heading   (rsp_heading)
   );

   // every response traces back to an earlier accepted transaction at the pipeline depth
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("response without matching request");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_heading <= HEADING_WIDTH'(HEADING_SCALE)))
      else $error("heading beyond full turn");

   // positive X axis bypasses CORDIC and must land exactly on half scale
   a_pos_x_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(accept && (req_field_y == '0) && !req_field_x[FIELD_WIDTH-1]
                           && (req_field_x != '0), LATENCY))
      |-> (rsp_heading == HEADING_AT_ZERO))
      else $error("positive X axis heading wrong");

endmodule

### hw/rtl/mhxy_prerot.sv
// Input stage: scales X/Y, rotates into the right half plane, flags axis cases.
// Depends on mhxy_pkg.
module mhxy_prerot (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [mhxy_pkg::FIELD_WIDTH-1:0] field_x,
   input  logic signed [mhxy_pkg::FIELD_WIDTH-1:0] field_y,
   output mhxy_pkg::cordic_item_type              item_out
);
   import mhxy_pkg::*;

   cordic_item_type item_ff, item_in;
   logic signed [XY_WIDTH-1:0] x_wide, y_wide;
   logic x_neg, y_pos, x_zero, y_zero;

   always_comb begin
      x_wide = XY_WIDTH'(field_x) <<< INPUT_SHIFT;
      y_wide = XY_WIDTH'(field_y) <<< INPUT_SHIFT;
      x_neg  = field_x[FIELD_WIDTH-1];
      x_zero = (field_x == '0);
      y_zero = (field_y == '0);
      y_pos  = !field_y[FIELD_WIDTH-1] && !y_zero;

      // drop the transaction while reset is high
      item_in.valid  = in_valid && !reset;
      item_in.bypass = x_zero || y_zero;
      item_in.x      = x_wide;
      item_in.y      = y_wide;
      item_in.z      = '0;

      if (y_zero) begin
         item_in.z = x_neg ? HALF_TURN : '0;
      end else if (x_zero) begin
         item_in.z = y_pos ? QUARTER_TURN : -QUARTER_TURN;
      end else if (x_neg) begin
         // rotate by -90 or +90 degrees to land in the right half plane
         if (y_pos) begin
            item_in.x = y_wide;
            item_in.y = -x_wide;
            item_in.z = QUARTER_TURN;
         end else begin
            item_in.x = -y_wide;
            item_in.y = x_wide;
            item_in.z = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_out = item_ff;

endmodule

### hw/rtl/mhxy_cordic.sv
// Unrolled CORDIC vectoring pipeline, one registered micro-rotation per stage.
// Depends on mhxy_pkg.
module mhxy_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  mhxy_pkg::cordic_item_type item_in,
   output mhxy_pkg::cordic_item_type item_out
);
   import mhxy_pkg::*;

   cordic_item_type stage_ff [1:CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      cordic_item_type prev, next_in;
      logic signed [XY_WIDTH-1:0] dx, dy;
      logic y_pos;

      if (i == 0) begin : g_head
         assign prev = item_in;
      end else begin : g_body
         assign prev = stage_ff[i];
      end

      always_comb begin
         dx      = prev.y >>> i;
         dy      = prev.x >>> i;
         y_pos   = !prev.y[XY_WIDTH-1] && (prev.y != '0);
         next_in = prev;
         // drop in-flight transactions while reset is high
         next_in.valid = prev.valid && !reset;
         if (!prev.bypass) begin
            if (y_pos) begin
               next_in.x = prev.x + dx;
               next_in.y = prev.y - dy;
               next_in.z = prev.z + arc_angle(i);
            end else begin
               next_in.x = prev.x - dx;
               next_in.y = prev.y + dy;
               next_in.z = prev.z - arc_angle(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[i+1] <= next_in;
      end
   end

   assign item_out = stage_ff[CORDIC_STAGES];

endmodule

### hw/rtl/mhxy_scale.sv
// Output stages: clamp the angle, offset by half a turn, scale to degrees, round.
// Depends on mhxy_pkg.
module mhxy_scale (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mhxy_pkg::cordic_item_type                item_in,
   output logic                                     out_valid,
   output logic [mhxy_pkg::HEADING_WIDTH-1:0]       heading
);
   import mhxy_pkg::*;

   logic                       turn_valid_ff;
   logic [TURN_WIDTH-1:0]      turn_ff, turn_in;
   logic                       prod_valid_ff;
   logic [PROD_WIDTH-1:0]      prod_ff;
   logic                       head_valid_ff;
   logic [HEADING_WIDTH-1:0]   heading_ff, heading_in;
   logic signed [Z_WIDTH-1:0]  z_clamped, z_offset;
   logic [ROUND_WIDTH-1:0]     rounded;

   always_comb begin
      z_clamped = item_in.z;
      if (item_in.z > HALF_TURN) begin
         z_clamped = HALF_TURN;
      end
      if (item_in.z < -HALF_TURN) begin
         z_clamped = -HALF_TURN;
      end
      z_offset = z_clamped + HALF_TURN;
      turn_in  = z_offset[TURN_WIDTH-1:0];
   end

   always_comb begin
      rounded    = ROUND_WIDTH'(prod_ff) + (ROUND_WIDTH'(1) << (TURN_BITS - 1));
      heading_in = rounded[TURN_BITS +: HEADING_WIDTH];
   end

   always_ff @(posedge clock) begin
      turn_ff    <= turn_in;
      prod_ff    <= PROD_WIDTH'(turn_ff) * PROD_WIDTH'(HEADING_SCALE);
      heading_ff <= heading_in;
      if (reset) begin
         turn_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         head_valid_ff <= 1'b0;
      end else begin
         turn_valid_ff <= item_in.valid;
         prod_valid_ff <= turn_valid_ff;
         head_valid_ff <= prod_valid_ff;
      end
   end

   assign out_valid = head_valid_ff;
   assign heading   = heading_ff;

endmodule

### tb/sv/tb_magnetic_heading_from_xy_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for magnetic_heading_from_xy_top: X/Y samples in, checked headings out.
// Depends on mhxy_pkg and the heading RTL; a class-based scoreboard predicts each heading.
module tb_magnetic_heading_from_xy_top;
   import mhxy_pkg::*;

   localparam int           RANDOM_SAMPLES = 950;
   localparam int           IDLE_LIMIT     = 2000;
   localparam longint       TURN_HALF      = 64'sd2147483648;
   localparam longint       TURN_QUARTER   = 64'sd1073741824;
   localparam longint       FIELD_GAIN     = 64'sd1073741824;
   localparam int           STEP_COUNT     = 24;
   localparam longint       ATAN_STEPS [STEP_COUNT] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };
   localparam logic signed [FIELD_WIDTH-1:0] CORNER_VALUES [6] = '{
      -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
   };

   class heading_board;
      logic [HEADING_WIDTH-1:0] expected_headings[$];
      int                       error_count = 0;
      int                       checked_count = 0;

      function logic [HEADING_WIDTH-1:0] predict_heading(logic signed [FIELD_WIDTH-1:0] fx,
                                                         logic signed [FIELD_WIDTH-1:0] fy);
         longint          x;
         longint          y;
         longint          z;
         longint          dx;
         longint          dy;
         longint          t;
         longint unsigned turn;
         longint unsigned scaled;
         longint unsigned scale;
         x = fx;
         y = fy;
         z = 0;
         scale = 64'd360 << ANGLE_FRACTION_BITS;
         if (y == 0) begin
            z = (x < 0) ? TURN_HALF : 0;
         end else if (x == 0) begin
            z = (y > 0) ? TURN_QUARTER : -TURN_QUARTER;
         end else begin
            x = x * FIELD_GAIN;
            y = y * FIELD_GAIN;
            // rotate the left half plane by +/-90 degrees before the iterations
            if (x < 0) begin
               if (y > 0) begin
                  t = x; x = y; y = -t; z = TURN_QUARTER;
               end else begin
                  t = x; x = -y; y = t; z = -TURN_QUARTER;
               end
            end
            for (int i = 0; i < CORDIC_ITERATIONS && i < STEP_COUNT; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y > 0) begin
                  x += dx; y -= dy; z += ATAN_STEPS[i];
               end else begin
                  x -= dx; y += dy; z -= ATAN_STEPS[i];
               end
            end
            if (z > TURN_HALF) z = TURN_HALF;
            if (z < -TURN_HALF) z = -TURN_HALF;
         end
         turn = longint'(z + TURN_HALF);
         scaled = (turn * scale + longint'(TURN_HALF)) >> 32;
         return scaled[HEADING_WIDTH-1:0];
      endfunction

      function void note_sample(logic signed [FIELD_WIDTH-1:0] fx,
                                logic signed [FIELD_WIDTH-1:0] fy);
         expected_headings.push_back(predict_heading(fx, fy));
      endfunction

      function void check_heading(logic [HEADING_WIDTH-1:0] actual);
         logic [HEADING_WIDTH-1:0] wanted;
         if (expected_headings.size() == 0) begin
            $error("unexpected transaction: heading %0d with nothing pending", actual);
            error_count++;
         end else begin
            wanted = expected_headings.pop_front();
            checked_count++;
            if (actual !== wanted) begin
               $error("heading mismatch: expected %0d, actual %0d", wanted, actual);
               error_count++;
            end
         end
      endfunction

      function int pending();
         return expected_headings.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [FIELD_WIDTH-1:0] req_field_x;
   logic signed [FIELD_WIDTH-1:0] req_field_y;
   logic                          rsp_strobe;
   logic [HEADING_WIDTH-1:0]      rsp_heading;

   heading_board board = new();
   int           idle_cycles = 0;
   int           sent_count = 0;
   int           axis_count = 0;
   bit           timed_out = 1'b0;

   magnetic_heading_from_xy_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_field_x (req_field_x),
      .req_field_y (req_field_y),
      .rsp_strobe  (rsp_strobe),
      .rsp_heading (rsp_heading)
   );

   always #5 clock = ~clock;

   // Record accepted samples and check headings on the same edge view
   always @(posedge clock) begin
      logic moved;
      moved = 1'b0;
      if (!reset && start && !busy) begin
         board.note_sample(req_field_x, req_field_y);
         moved = 1'b1;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_heading(rsp_heading);
         moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
   end

   task automatic send_sample(input logic signed [FIELD_WIDTH-1:0] fx,
                              input logic signed [FIELD_WIDTH-1:0] fy,
                              input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_field_x <= fx;
      req_field_y <= fy;
      // hold until the transaction is taken
      do @(posedge clock); while (busy);
      sent_count++;
      if (fx == 0 || fy == 0) axis_count++;
   endtask

   task automatic run_directed();
      logic signed [FIELD_WIDTH-1:0] dir_x [22];
      logic signed [FIELD_WIDTH-1:0] dir_y [22];
      dir_x = '{0, -5, 5, 0, 0, 32767, -32768, 0, 0, -32768, 32767,
                -32768, 32767, -1, 1, -1, -32768, -32768, 1, -1, 0, 100};
      dir_y = '{0, 0, 0, 5, -5, 0, 0, -32768, 32767, -32768, 32767,
                32767, -32768, -1, -1, 1, 1, -1, 1, 0, -1, 100};
      for (int i = 0; i < 22; i++)
         send_sample(dir_x[i], dir_y[i], (i % 3 == 0) ? 0 : $urandom_range(0, 16));
   endtask

   task automatic run_random();
      logic signed [FIELD_WIDTH-1:0] fx;
      logic signed [FIELD_WIDTH-1:0] fy;
      bit                            back_to_back;
      int                            gap;
      back_to_back = 1'b0;
      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         if (n % 64 == 0) back_to_back = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 9))
            5: begin
               fx = FIELD_WIDTH'(int'($urandom_range(0, 16)) - 8);
               fy = FIELD_WIDTH'(int'($urandom_range(0, 16)) - 8);
            end
            6: begin
               fx = FIELD_WIDTH'($urandom);
               fy = FIELD_WIDTH'(int'($urandom_range(0, 4)) - 2);
               if ($urandom_range(0, 1)) begin
                  fy = fx;
                  fx = FIELD_WIDTH'(int'($urandom_range(0, 4)) - 2);
               end
            end
            7: begin
               fx = CORNER_VALUES[$urandom_range(0, 5)];
               fy = CORNER_VALUES[$urandom_range(0, 5)];
            end
            8: begin
               fx = FIELD_WIDTH'($urandom);
               fy = $urandom_range(0, 1) ? fx : -fx;
            end
            9: begin
               // negative X with Y near zero sits next to the +/-180 degree seam
               fx = -FIELD_WIDTH'($urandom_range(1, 32767));
               fy = FIELD_WIDTH'(int'($urandom_range(0, 64)) - 32);
            end
            default: begin
               fx = FIELD_WIDTH'($urandom);
               fy = FIELD_WIDTH'($urandom);
            end
         endcase
         gap = back_to_back ? 0 : $urandom_range(0, 16);
         send_sample(fx, fy, gap);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_field_x <= '0;
      req_field_y <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         begin
            run_directed();
            run_random();
            start <= 1'b0;
            while (board.pending() != 0) @(posedge clock);
            // let any stray result show up
            repeat (LATENCY + 4) @(posedge clock);
         end
         begin
            while (idle_cycles < IDLE_LIMIT) @(posedge clock);
            timed_out = 1'b1;
         end
      join_any
      disable fork;
      if (timed_out) begin
         $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
         $display("[magnetic_heading_from_xy_top] ERROR");
      end else begin
         $display("Sent %0d samples (%0d on an axis or at the origin), checked %0d headings.",
                  sent_count, axis_count, board.checked_count);
         if (board.error_count == 0)
            $display("[magnetic_heading_from_xy_top] OK");
         else
            $display("[magnetic_heading_from_xy_top] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/mhxy_pkg.sv
hw/rtl/mhxy_prerot.sv
hw/rtl/mhxy_cordic.sv
hw/rtl/mhxy_scale.sv
hw/rtl/magnetic_heading_from_xy_top.sv
tb/sv/tb_magnetic_heading_from_xy_top.sv
